@@ rtl/core/gb5_pkg.sv @@
// ----------------------------------------------------------------------------
// gb5_pkg: shared types and constants of the 5x5 Gaussian blur
// Widths, item codes, the inter-stage column item and the 1-4-6-4-1 weighting.
// ----------------------------------------------------------------------------
package gb5_pkg;

  // Line store geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int BANKS        = 8;
  localparam int BANK_W       = $clog2(BANKS);

  // Frame size registers
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int ROWX_W       = HEIGHT_W + 1;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int OUT_ROW_W    = $clog2(HEIGHT_LIMIT);
  localparam int LEAD_W       = WIDTH_W + 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HEIGHT_W;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Datapath
  localparam int TAPS   = 5;
  localparam int SEL_W  = $clog2(TAPS);
  localparam int PIX_W  = 8;
  localparam int VSUM_W = PIX_W + 4;
  localparam int SUM_W  = PIX_W + 8;

  // Column queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result queue
  localparam int ODEPTH = 2;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                restart;
  } cfg_t;

  typedef struct packed {
    logic [VSUM_W-1:0]              vsum;
    logic                           has_out;
    logic                           last;
    logic [TAPS-1:0][SEL_W-1:0]     sel;
  } col_item_t;

  // 1-4-6-4-1 weighted sum of five values
  function automatic logic [SUM_W-1:0] weigh5(input logic [VSUM_W-1:0] a,
                                              input logic [VSUM_W-1:0] b,
                                              input logic [VSUM_W-1:0] c,
                                              input logic [VSUM_W-1:0] d,
                                              input logic [VSUM_W-1:0] e);
    logic [SUM_W-1:0] xa, xb, xc, xd, xe;
    xa = SUM_W'(a);
    xb = SUM_W'(b);
    xc = SUM_W'(c);
    xd = SUM_W'(d);
    xe = SUM_W'(e);
    return xa + xe + ((xb + xd) << 2) + (xc << 2) + (xc << 1);
  endfunction

endpackage

@@ rtl/core/gb5_front.sv @@
// ----------------------------------------------------------------------------
// gb5_front: input side of the blur
// Accepts items, writes the banked line store, tracks frame position and
// forms one vertical 1-4-6-4-1 column sum per stream slot.
// ----------------------------------------------------------------------------
module gb5_front
  import gb5_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic [PIX_W-1:0]      pixel_in,
  input  logic [QCNT_W-1:0]     mq_count,
  output logic                  mq_push,
  output col_item_t             mq_item
);

  localparam logic [1:0] WARM_FULL = 2'd2;

  // Bank of the clamped row r + k - 2
  function automatic logic [BANK_W-1:0] row_bank(input logic [HEIGHT_W-1:0] r,
                                                 input logic [SEL_W-1:0]    k,
                                                 input logic [HEIGHT_W-1:0] hm1);
    logic [ROWX_W-1:0] lo, t;
    lo = {1'b0, r} + ROWX_W'(k);
    t  = lo - ROWX_W'(2);
    if (lo < ROWX_W'(2)) return '0;
    if (t > {1'b0, hm1}) return hm1[BANK_W-1:0];
    return t[BANK_W-1:0];
  endfunction

  logic [COL_W-1:0]     in_col, q_col, out_col;
  logic [HEIGHT_W-1:0]  in_row, q_row;
  logic [OUT_ROW_W-1:0] out_row;
  logic [LEAD_W-1:0]    lead;
  logic [1:0]           warm;

  logic [COL_W-1:0]     w_m1, rem;
  logic [HEIGHT_W-1:0]  h_m1;
  logic accept, pix_phase, counted, wr_en, active, slot, has_out, last, restart_frame;

  logic [TAPS-1:0][BANK_W-1:0] bank;
  logic [TAPS-1:0][SEL_W-1:0]  sel;
  logic [BANKS-1:0]            hit;

  logic                        f1_valid, f1_has_out, f1_last;
  logic [TAPS-1:0][BANK_W-1:0] f1_bank;
  logic [TAPS-1:0][SEL_W-1:0]  f1_sel;
  logic [BANKS-1:0]            f1_hit;
  logic [PIX_W-1:0]            byp_pix;
  logic [BANKS-1:0][PIX_W-1:0] rd_data;
  logic [TAPS-1:0][PIX_W-1:0]  row_pix;

  always_comb begin
    w_m1      = COL_W'(cfg.width - WIDTH_W'(1));
    h_m1      = cfg.height - HEIGHT_W'(1);
    rem       = w_m1 - out_col;
    full      = (mq_count + QCNT_W'(f1_valid)) >= QCNT_W'(QDEPTH);
    accept    = push && !full;
    pix_phase = in_row < cfg.height;
    // a flush inside the frame is dropped; after the frame every item drains
    counted   = accept && !(pix_phase && (opcode_t'(opcode) == OP_FLUSH));
    wr_en     = counted && pix_phase;
    active    = lead == {cfg.width, 1'b0};
    slot      = counted && active;
    has_out   = warm == WARM_FULL;
    last      = has_out && (out_row == OUT_ROW_W'(h_m1)) && (out_col == w_m1);
    restart_frame = cfg.restart || (slot && last);
  end

  // Row banks and horizontal tap selects with replicated borders
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      bank[i] = row_bank(q_row, SEL_W'(i), h_m1);
    end
    sel[0] = (out_col >= COL_W'(2)) ? SEL_W'(4) :
             (out_col == COL_W'(1)) ? SEL_W'(3) : SEL_W'(2);
    sel[1] = (out_col >= COL_W'(1)) ? SEL_W'(3) : SEL_W'(2);
    sel[2] = SEL_W'(2);
    sel[3] = (rem >= COL_W'(1)) ? SEL_W'(1) : SEL_W'(2);
    sel[4] = (rem >= COL_W'(2)) ? SEL_W'(0) :
             (rem == COL_W'(1)) ? SEL_W'(1) : SEL_W'(2);
    for (int b = 0; b < BANKS; b++) begin
      hit[b] = wr_en && (in_row[BANK_W-1:0] == BANK_W'(b)) && (in_col == q_col);
    end
  end

  // Frame position counters
  always_ff @(posedge clk) begin
    if (rst || restart_frame) begin
      in_col  <= '0;
      in_row  <= '0;
      lead    <= '0;
      q_col   <= '0;
      q_row   <= '0;
      warm    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (wr_en) begin
        if (in_col == w_m1) begin
          in_col <= '0;
          in_row <= in_row + HEIGHT_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (counted && !active) begin
        lead <= lead + LEAD_W'(1);
      end
      if (slot) begin
        if (q_col == w_m1) begin
          q_col <= '0;
          q_row <= q_row + HEIGHT_W'(1);
        end else begin
          q_col <= q_col + COL_W'(1);
        end
        if (!has_out) begin
          warm <= warm + 2'd1;
        end else if (out_col == w_m1) begin
          out_col <= '0;
          out_row <= out_row + OUT_ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Line store: one bank per row slot, one write and one read port each
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (wr_en && (in_row[BANK_W-1:0] == BANK_W'(b))) begin
        bank_mem[in_col] <= pixel_in;
      end
      if (slot) begin
        rd_data[b] <= bank_mem[q_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (slot) begin
      f1_has_out <= has_out;
      f1_last    <= last;
      f1_sel     <= sel;
      f1_bank    <= bank;
      f1_hit     <= hit;
      byp_pix    <= pixel_in;
    end
  end

  // Take the pixel written in the same cycle where it collides with the read
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      row_pix[i] = f1_hit[f1_bank[i]] ? byp_pix : rd_data[f1_bank[i]];
    end
    mq_push         = f1_valid;
    mq_item.vsum    = VSUM_W'(weigh5(VSUM_W'(row_pix[0]), VSUM_W'(row_pix[1]),
                                     VSUM_W'(row_pix[2]), VSUM_W'(row_pix[3]),
                                     VSUM_W'(row_pix[4])));
    mq_item.has_out = f1_has_out;
    mq_item.last    = f1_last;
    mq_item.sel     = f1_sel;
  end

endmodule

@@ rtl/core/gb5_queue.sv @@
// ----------------------------------------------------------------------------
// gb5_queue: column item queue
// Small circular queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module gb5_queue
  import gb5_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  col_item_t         item_in,
  input  logic              pop,
  output logic              valid,
  output col_item_t         item_out,
  output logic [QCNT_W-1:0] count
);

  col_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign valid    = count != '0;
  assign item_out = slots[rptr];

endmodule

@@ rtl/core/gb5_back.sv @@
// ----------------------------------------------------------------------------
// gb5_back: horizontal pass and result queue
// Shifts column sums into a five-tap window, forms the 1-4-6-4-1 sum with
// border selects and queues the finished pixel.
// ----------------------------------------------------------------------------
module gb5_back
  import gb5_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              mq_valid,
  input  col_item_t         mq_item,
  output logic              mq_pop,
  input  logic              pop,
  output logic              empty,
  output logic [PIX_W-1:0]  blurred_pixel,
  output logic              frame_end
);

  function automatic logic [VSUM_W-1:0] pick(input logic [TAPS-1:0][VSUM_W-1:0] t,
                                             input logic [SEL_W-1:0] s);
    return (s < SEL_W'(TAPS)) ? t[s] : t[0];
  endfunction

  logic [TAPS-1:0][VSUM_W-1:0] taps, taps_next;
  logic [TAPS-1:0][VSUM_W-1:0] pix;
  logic [SUM_W-1:0]            sum;

  logic [PIX_W-1:0]  o_pix [ODEPTH];
  logic              o_end [ODEPTH];
  logic [OPTR_W-1:0] o_wptr, o_rptr;
  logic [OCNT_W-1:0] o_count;
  logic pop_fire, space, take, o_push;

  always_comb begin
    taps_next = {taps[TAPS-2:0], mq_item.vsum};
    for (int i = 0; i < TAPS; i++) begin
      pix[i] = pick(taps_next, mq_item.sel[i]);
    end
    sum      = weigh5(pix[0], pix[1], pix[2], pix[3], pix[4]);
    pop_fire = pop && !empty;
    space    = (o_count != OCNT_W'(ODEPTH)) || pop_fire;
    take     = mq_valid && (!mq_item.has_out || space);
    o_push   = take && mq_item.has_out;
    mq_pop   = take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      taps <= taps_next;
    end
    if (o_push) begin
      o_pix[o_wptr] <= sum[SUM_W-1 -: PIX_W];
      o_end[o_wptr] <= mq_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wptr  <= '0;
      o_rptr  <= '0;
      o_count <= '0;
    end else begin
      if (o_push) begin
        o_wptr <= o_wptr + OPTR_W'(1);
      end
      if (pop_fire) begin
        o_rptr <= o_rptr + OPTR_W'(1);
      end
      unique case ({o_push, pop_fire})
        2'b10:   o_count <= o_count + OCNT_W'(1);
        2'b01:   o_count <= o_count - OCNT_W'(1);
        default: o_count <= o_count;
      endcase
    end
  end

  assign empty         = o_count == '0;
  assign blurred_pixel = o_pix[o_rptr];
  assign frame_end     = o_end[o_rptr];

endmodule

@@ rtl/core/gaussian_blur_5x5.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_5x5: streaming 5x5 Gaussian blur with replicated borders
// Raster-order 8-bit grey pixels in, floor(weighted sum / 256) pixels out.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------
//   input    push / full            opcode, pixel_in
//   result   empty / pop            blurred_pixel, frame_end
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while full stays low and the back is not stalled;
// the front, the column queue and the back each pass one item a cycle. A result
// reaches the result ports through the registered line store read port and read
// stage, then the column queue, then the result queue.
// full rises when the four-entry column queue plus the item in the read stage
// would fill it; the back stalls only on a full two-entry result queue.
// Reset clears counters and queues; the line store is not cleared, since no
// output reads a line entry before it is written.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5
  import gb5_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic [PIX_W-1:0]      pixel_in,
  // result items
  input  logic                  pop,
  output logic                  empty,
  output logic [PIX_W-1:0]      blurred_pixel,
  output logic                  frame_end,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic                cfg_fire;
  cfg_t                cfg;

  logic              mq_push, mq_pop, mq_valid;
  col_item_t         mq_in, mq_out;
  logic [QCNT_W-1:0] mq_count;

  // Configuration is always taken; a write to a known register restarts
  // the frame in progress.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size: zero acts as one, oversize acts as the limit.
  always_comb begin
    if (width_reg == '0) begin
      cfg.width = WIDTH_W'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      cfg.width = WIDTH_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_reg;
    end
    if (height_reg == '0) begin
      cfg.height = HEIGHT_W'(1);
    end else if (32'(height_reg) > HEIGHT_LIMIT) begin
      cfg.height = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      cfg.height = height_reg;
    end
    cfg.restart = cfg_fire &&
                  ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
  end

  // Front: accept, line store, vertical sums
  gb5_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .opcode   (opcode),
    .pixel_in (pixel_in),
    .mq_count (mq_count),
    .mq_push  (mq_push),
    .mq_item  (mq_in)
  );

  // Column queue between the two halves
  gb5_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mq_push),
    .item_in  (mq_in),
    .pop      (mq_pop),
    .valid    (mq_valid),
    .item_out (mq_out),
    .count    (mq_count)
  );

  // Back: horizontal sums and result queue
  gb5_back u_back (
    .clk           (clk),
    .rst           (rst),
    .mq_valid      (mq_valid),
    .mq_item       (mq_out),
    .mq_pop        (mq_pop),
    .pop           (pop),
    .empty         (empty),
    .blurred_pixel (blurred_pixel),
    .frame_end     (frame_end)
  );

  // The credit in the front must keep the column queue from overflowing.
  a_queue_room : assert property (@(posedge clk) disable iff (rst)
    mq_push |-> (mq_count < QCNT_W'(QDEPTH)))
    else $error("column queue written while full");

  // The back only drains items that are there.
  a_queue_drain : assert property (@(posedge clk) disable iff (rst)
    mq_pop |-> (mq_count != '0))
    else $error("column queue read while empty");

  // Reset leaves no result behind.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

@@ dv/blur_check_pkg.sv @@
// ----------------------------------------------------------------------------
// blur_check_pkg: expected-result tracker for the 5x5 Gaussian blur
// Mirrors the frame counters and the line rows, works out each blurred pixel
// and compares the pixels that leave the block in order.
// ----------------------------------------------------------------------------
package blur_check_pkg;
  import gb5_pkg::*;

  localparam int STORE_ROWS   = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             frame_end;
  } blur_result_t;

  class blur_checker;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    line_mem [STORE_ROWS*MAX_WIDTH];
    int unsigned         in_col, in_row, out_col, out_row, fed;
    blur_result_t        pending_blur[$];
    int unsigned         fault_count;

    function new();
      width_reg   = WIDTH_RESET;
      height_reg  = HEIGHT_RESET;
      fault_count = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      rewind();
    endfunction

    function void rewind();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      fed     = 0;
    endfunction

    function int unsigned cols();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned rows();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function int unsigned binomial(int k);
      if (k == 2) return 6;
      if (k == 1 || k == 3) return 4;
      return 1;
    endfunction

    function int unsigned border_clamp(int v, int unsigned lim);
      if (v < 0) return 0;
      if (v >= int'(lim)) return lim - 1;
      return v;
    endfunction

    function void fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // any valid index abandons the frame in progress
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          rewind();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
          rewind();
        end
        default: ;
      endcase
    endfunction

    function void take_item(opcode_t op, logic [PIX_W-1:0] px);
      int unsigned  w, h, sum, r, c;
      int           dy, dx;
      logic         done;
      blur_result_t res;
      w = cols();
      h = rows();
      if (in_row < h) begin
        // drop a flush while the frame still takes pixels
        if (op == OP_FLUSH) return;
        line_mem[(in_row % STORE_ROWS) * MAX_WIDTH + in_col] = px;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      fed++;
      if (fed < out_row * w + out_col + 2 * w + 3) return;
      sum = 0;
      for (dy = -2; dy <= 2; dy++) begin
        r = border_clamp(int'(out_row) + dy, h);
        for (dx = -2; dx <= 2; dx++) begin
          c = border_clamp(int'(out_col) + dx, w);
          sum += binomial(dy + 2) * binomial(dx + 2) *
                 line_mem[(r % STORE_ROWS) * MAX_WIDTH + c];
        end
      end
      done = (out_row == h - 1) && (out_col == w - 1);
      res.blurred   = PIX_W'(sum >> 8);
      res.frame_end = done;
      pending_blur.push_back(res);
      if (done) begin
        rewind();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic fe);
      blur_result_t want;
      if (pending_blur.size() == 0) begin
        fault($sformatf("unexpected item: blurred_pixel=%0d frame_end=%0b", pix, fe));
        return;
      end
      want = pending_blur.pop_front();
      if (pix !== want.blurred)
        fault($sformatf("blurred_pixel mismatch: expected %0d, got %0d", want.blurred, pix));
      if (fe !== want.frame_end)
        fault($sformatf("frame_end mismatch: expected %0b, got %0b", want.frame_end, fe));
    endfunction

    function int unsigned outstanding();
      return pending_blur.size();
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming 5x5 Gaussian blur
// Programs frame sizes, streams raster frames with random grey levels, stray
// flushes and drain items, and checks every blurred pixel and end-of-frame
// flag against a cycle-free model, under several push/pop idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gb5_pkg::*;
  import blur_check_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 120;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  opcode    = OP_PIXEL;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full, empty, frame_end, cfg_ready;
  logic [PIX_W-1:0]      blurred_pixel;

  int          idle_pct    = 0;
  int          stall_pct   = 0;
  logic        long_hold   = 1'b0;
  int unsigned hold_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned cur_w       = 640;
  int unsigned cur_h       = 480;
  int unsigned counted     = 0;

  blur_checker chk = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gaussian_blur_5x5 uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .pixel_in      (pixel_in),
    .pop           (pop),
    .empty         (empty),
    .blurred_pixel (blurred_pixel),
    .frame_end     (frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Monitor: everything is sampled at the edge, before the block updates.
  // Check the leaving item first; it was always caused by an earlier input.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) chk.check_result(blurred_pixel, frame_end);
      if (push && !full) chk.take_item(opcode_t'(opcode), pixel_in);
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_index, cfg_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here while
  // long_hold is up, so the block fills and raises full.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (long_hold && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      pop        <= 1'b0;
    end else begin
      if (!long_hold) hold_count <= 0;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item, idling first at random; return at the accepting edge
  // with push still high so back-to-back items need no extra assignment.
  task automatic send_item(input opcode_t op, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < idle_pct) begin
      push     <= 1'b0;
      opcode   <= 1'($urandom);
      pixel_in <= PIX_W'($urandom);
      @(posedge clk);
    end
    push     <= 1'b1;
    opcode   <= op;
    pixel_in <= px;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
  endtask

  // Raster pixels, with the odd stray flush that the block must ignore
  task automatic send_pixels(input int unsigned n);
    logic [PIX_W-1:0] px;
    repeat (n) begin
      if ($urandom_range(99) < 6) send_item(OP_FLUSH, PIX_W'($urandom));
      case ($urandom_range(9))
        0:       px = '0;
        1:       px = '1;
        default: px = PIX_W'($urandom);
      endcase
      send_item(OP_PIXEL, px);
      counted++;
    end
  endtask

  // Drain items after the last pixel; a pixel here acts as a flush
  task automatic send_drain(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < 15) send_item(OP_PIXEL, PIX_W'($urandom));
      else send_item(OP_FLUSH, PIX_W'($urandom));
      counted++;
    end
  endtask

  task automatic stream_frame();
    send_pixels(cur_w * cur_h);
    send_drain(2 * cur_w + 2);
  endtask

  // Hold the sender until every expected item has left
  task automatic quiesce();
    push <= 1'b0;
    do @(posedge clk); while (chk.outstanding() != 0);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  // Reprogram the frame size on an idle block; flushes may still be in
  // flight after the last result, so give the pipe time to empty.
  task automatic set_frame(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata, input bit spare);
    int unsigned wv;
    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_put(REG_FRAME_WIDTH, wdata);
    if (spare) cfg_put(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_put(REG_FRAME_HEIGHT, hdata);
    cfg_valid <= 1'b0;
    wv    = wdata[WIDTH_W-1:0];
    cur_w = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
    cur_h = (hdata == 0) ? 1 : ((hdata > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hdata);
  endtask

  // Mostly whole small frames; now and then cut a frame short and reprogram
  task automatic random_phase(input int unsigned budget);
    int unsigned      stop_at, w, h;
    logic [CFG_DATA_W-1:0] wd, hd;
    bit               must_cfg;
    stop_at  = counted + budget;
    must_cfg = 1'b1;
    while (counted < stop_at) begin
      if (must_cfg || $urandom_range(99) < 45) begin
        w  = ($urandom_range(99) < 75) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        h  = (w <= 2) ? $urandom_range(1, 12) : $urandom_range(1, 5);
        // upper data bits are not part of the width register
        wd = CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(3)) << WIDTH_W);
        hd = CFG_DATA_W'(h);
        if ($urandom_range(99) < 5) wd = '0;
        if ($urandom_range(99) < 5) hd = '0;
        set_frame(wd, hd, 1'b0);
        must_cfg = 1'b0;
      end
      if ($urandom_range(99) < 10) begin
        send_pixels($urandom_range(0, cur_w * cur_h));
        must_cfg = 1'b1;
      end else begin
        stream_frame();
      end
    end
  endtask

  initial begin
    int idle_mode [4];
    int stall_mode[4];
    idle_mode  = '{0, 49, 0, 21};
    stall_mode = '{0, 0, 49, 21};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3x3 frame with extreme levels, a stray flush mid-frame,
    // a pixel among the drain items, then a flush on the fresh frame
    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(3), 1'b1);
    send_item(OP_PIXEL, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    send_item(OP_FLUSH, 8'd255);
    send_item(OP_PIXEL, 8'hAA);
    send_item(OP_PIXEL, 8'h55);
    send_item(OP_PIXEL, 8'd1);
    send_item(OP_PIXEL, 8'd254);
    send_item(OP_PIXEL, 8'd128);
    send_item(OP_PIXEL, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    repeat (3) send_item(OP_FLUSH, 8'd0);
    send_item(OP_PIXEL, 8'd77);
    repeat (4) send_item(OP_FLUSH, 8'hFF);
    send_item(OP_FLUSH, 8'd0);
    // abandon a frame partway; the next write restarts it
    repeat (3) send_item(OP_PIXEL, 8'd255);

    // Random frames under each idling pattern
    for (int m = 0; m < 4; m++) begin
      idle_pct  = idle_mode[m];
      stall_pct <= stall_mode[m];
      random_phase(70);
    end

    // Back-pressure: receiver holds off while the sender keeps offering
    idle_pct  = 0;
    stall_pct <= 0;
    set_frame(CFG_DATA_W'(4), CFG_DATA_W'(6), 1'b0);
    long_hold <= 1'b1;
    stream_frame();
    long_hold <= 1'b0;

    // Sender pause mid-frame until every pending item has come out
    set_frame(CFG_DATA_W'(5), CFG_DATA_W'(4), 1'b0);
    send_pixels(15);
    quiesce();
    send_pixels(5);
    send_drain(12);

    // Register extremes: opening rows of the widest and tallest frames,
    // masked and zero sizes
    idle_pct  = 21;
    stall_pct <= 21;
    set_frame(CFG_DATA_W'(1024), CFG_DATA_W'(2), 1'b0);
    send_pixels(20);
    set_frame(13'h1FFF, CFG_DATA_W'(1), 1'b0);
    send_pixels(8);
    set_frame(13'h0000, 13'h0000, 1'b0);
    stream_frame();
    stream_frame();
    set_frame(13'h1801, CFG_DATA_W'(4096), 1'b0);
    send_pixels(20);
    set_frame(CFG_DATA_W'(1), 13'h1FFF, 1'b0);
    send_pixels(12);

    // Drain, then watch for stray items before the verdict
    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.fault_count == 0 && chk.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ gaussian_blur_5x5.f @@
rtl/core/gb5_pkg.sv
rtl/core/gb5_front.sv
rtl/core/gb5_queue.sv
rtl/core/gb5_back.sv
rtl/core/gaussian_blur_5x5.sv
dv/blur_check_pkg.sv
dv/tb_top.sv
